// ===== sv/chacha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha package
// shared types and constants for the chacha20 stream cipher
// ----------------------------------------------------------------------------
package chacha_pkg;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   localparam logic [2:0] REG_KEY01    = 3'd0;
   localparam logic [2:0] REG_KEY23    = 3'd1;
   localparam logic [2:0] REG_KEY45    = 3'd2;
   localparam logic [2:0] REG_KEY67    = 3'd3;
   localparam logic [2:0] REG_NONCE_LO = 3'd4;
   localparam logic [2:0] REG_NONCE_HI = 3'd5;

   typedef logic [15:0][31:0] state_type;

   typedef struct packed {
      logic load;
      logic round;
      logic finish;
      logic emit;
      logic take;
   } cmd_type;

   typedef struct packed {
      logic need_block;
      logic last_round;
   } stat_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] a1, b1, c1, d1;
      a1 = a + b;   d1 = rotl(d ^ a1, 16);
      c1 = c + d1;  b1 = rotl(b ^ c1, 12);
      a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
      c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
      quarter = {d1, c1, b1, a1};
   endfunction

endpackage

// ===== sv/chacha_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha datapath
// block state, one half double round per cycle, key stream and output word
// ----------------------------------------------------------------------------
module chacha_datapath #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  chacha_pkg::cmd_type cmd,
   output chacha_pkg::stat_type stat,
   input  logic                cfg_we,
   input  logic [2:0]          cfg_idx,
   input  logic [63:0]         cfg_data,
   input  logic [31:0]         in_word,
   input  logic [2:0]          in_count,
   input  logic                in_last,
   output logic [31:0]         out_word,
   output logic [2:0]          out_count,
   output logic                out_last
);
   localparam int STEPS = 2 * DOUBLE_ROUNDS;
   localparam int RW = $clog2(STEPS);

   logic [63:0] key01_ff, key23_ff, key45_ff, key67_ff, nlo_ff;
   logic [31:0] nhi_ff;
   logic [31:0] ctr_ff, ctr_in;
   logic [3:0]  pos_ff, pos_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   chacha_pkg::state_type init_ff, work_ff, work_in, ks_ff, ks_in, init_in, half;
   logic [31:0] dw_ff;
   logic [2:0]  dc_ff;
   logic        dl_ff;
   logic [31:0] res_ff, mask;
   logic [2:0]  cnt_ff;
   logic        last_ff;
   logic [127:0] q0, q1, q2, q3;

   always_comb begin
      init_in[0] = chacha_pkg::SIGMA0;
      init_in[1] = chacha_pkg::SIGMA1;
      init_in[2] = chacha_pkg::SIGMA2;
      init_in[3] = chacha_pkg::SIGMA3;
      init_in[4] = key01_ff[31:0];  init_in[5] = key01_ff[63:32];
      init_in[6] = key23_ff[31:0];  init_in[7] = key23_ff[63:32];
      init_in[8] = key45_ff[31:0];  init_in[9] = key45_ff[63:32];
      init_in[10] = key67_ff[31:0]; init_in[11] = key67_ff[63:32];
      init_in[12] = ctr_ff;
      init_in[13] = nlo_ff[31:0];   init_in[14] = nlo_ff[63:32];
      init_in[15] = nhi_ff;
   end

   always_comb begin
      half = work_ff;
      if (!rnd_ff[0]) begin
         q0 = chacha_pkg::quarter(work_ff[0], work_ff[4], work_ff[8],  work_ff[12]);
         q1 = chacha_pkg::quarter(work_ff[1], work_ff[5], work_ff[9],  work_ff[13]);
         q2 = chacha_pkg::quarter(work_ff[2], work_ff[6], work_ff[10], work_ff[14]);
         q3 = chacha_pkg::quarter(work_ff[3], work_ff[7], work_ff[11], work_ff[15]);
         {half[12], half[8],  half[4], half[0]} = q0;
         {half[13], half[9],  half[5], half[1]} = q1;
         {half[14], half[10], half[6], half[2]} = q2;
         {half[15], half[11], half[7], half[3]} = q3;
      end else begin
         q0 = chacha_pkg::quarter(work_ff[0], work_ff[5], work_ff[10], work_ff[15]);
         q1 = chacha_pkg::quarter(work_ff[1], work_ff[6], work_ff[11], work_ff[12]);
         q2 = chacha_pkg::quarter(work_ff[2], work_ff[7], work_ff[8],  work_ff[13]);
         q3 = chacha_pkg::quarter(work_ff[3], work_ff[4], work_ff[9],  work_ff[14]);
         {half[15], half[10], half[5], half[0]} = q0;
         {half[12], half[11], half[6], half[1]} = q1;
         {half[13], half[8],  half[7], half[2]} = q2;
         {half[14], half[9],  half[4], half[3]} = q3;
      end
   end

   always_comb begin
      work_in = work_ff;
      rnd_in  = rnd_ff;
      ks_in   = ks_ff;
      if (cmd.load) begin
         work_in = init_in;
         rnd_in  = '0;
      end else if (cmd.round) begin
         work_in = half;
         rnd_in  = rnd_ff + RW'(1);
      end
      if (cmd.finish) begin
         for (int i = 0; i < 16; i++) ks_in[i] = work_ff[i] + init_ff[i];
      end
   end

   always_comb begin
      ctr_in = ctr_ff;
      pos_in = pos_ff;
      if (cmd.load) ctr_in = ctr_ff + 32'd1;
      if (cmd.emit) begin
         pos_in = pos_ff + 4'd1;
         if (dl_ff) begin
            pos_in = '0;
            ctr_in = 32'd1;
         end
      end
   end

   always_comb begin
      case (dc_ff)
         3'd0: mask = 32'h0;
         3'd1: mask = 32'h0000_00ff;
         3'd2: mask = 32'h0000_ffff;
         3'd3: mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff <= '0; key23_ff <= '0; key45_ff <= '0; key67_ff <= '0;
         nlo_ff <= '0; nhi_ff <= '0;
         ctr_ff <= 32'd1;
         pos_ff <= '0;
         rnd_ff <= '0;
      end else begin
         ctr_ff <= ctr_in;
         pos_ff <= pos_in;
         rnd_ff <= rnd_in;
         if (cfg_we) begin
            unique case (cfg_idx)
               chacha_pkg::REG_KEY01:    key01_ff <= cfg_data;
               chacha_pkg::REG_KEY23:    key23_ff <= cfg_data;
               chacha_pkg::REG_KEY45:    key45_ff <= cfg_data;
               chacha_pkg::REG_KEY67:    key67_ff <= cfg_data;
               chacha_pkg::REG_NONCE_LO: nlo_ff <= cfg_data;
               chacha_pkg::REG_NONCE_HI: nhi_ff <= cfg_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ks_ff   <= ks_in;
      if (cmd.load) init_ff <= init_in;
      if (cmd.take) begin
         dw_ff <= in_word;
         dc_ff <= in_count;
         dl_ff <= in_last;
      end
      if (cmd.emit) begin
         res_ff  <= (dw_ff ^ ks_ff[pos_ff]) & mask;
         cnt_ff  <= dc_ff;
         last_ff <= dl_ff;
      end
   end

   assign stat.need_block = (pos_ff == 4'd0);
   assign stat.last_round = (rnd_ff == RW'(STEPS - 1));
   assign out_word  = res_ff;
   assign out_count = cnt_ff;
   assign out_last  = last_ff;

endmodule

// ===== sv/chacha_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha controller
// sequences request capture, block generation and result handoff
// ----------------------------------------------------------------------------
module chacha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  chacha_pkg::stat_type stat,
   output chacha_pkg::cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOAD   = 5'b00010,
      S_ROUND  = 5'b00100,
      S_FINISH = 5'b01000,
      S_EMIT   = 5'b10000
   } st_type;

   st_type st_ff, st_in;
   logic   ov_ff, ov_in;

   always_comb begin
      st_in = st_ff;
      cmd = '0;
      ov_in = ov_ff && !rsp_tready;
      req_tready = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               st_in = stat.need_block ? S_LOAD : S_EMIT;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            st_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (stat.last_round) st_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            st_in = S_EMIT;
         end
         S_EMIT: begin
            if (!ov_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               ov_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;

endmodule

// ===== sv/chacha20_stream_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20 stream cipher top
// encrypts packet words with a chacha20 key stream
// ----------------------------------------------------------------------------
// channel | direction | contents
// req_    | in        | tdata: in_word[31:0], byte_count[34:32]; tlast: last_of_packet
// rsp_    | out       | tdata: out_word[31:0], out_byte_count[34:32]; tlast: out_last
// csr_    | in        | index [2:0], data [63:0]
// a word passes idle and emit; the first word of each block also passes load,
// round and finish, one half double round per cycle in the shared round unit
// reset gives counter one and word position zero; no clearing pass
// a held result stalls the next word only once it is ready to leave
module chacha20_stream_cipher_top #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // in_word, byte_count
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_word, out_byte_count
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   chacha_pkg::cmd_type  cmd;
   chacha_pkg::stat_type stat;
   logic [31:0] ow;
   logic [2:0]  oc;

   assign csr_ready = 1'b1;

   chacha_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   chacha_datapath #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .cfg_we(csr_valid), .cfg_idx(csr_index), .cfg_data(csr_data),
      .in_word(req_tdata[31:0]), .in_count(req_tdata[34:32]), .in_last(req_tlast),
      .out_word(ow), .out_count(oc), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, oc, ow};

endmodule

// ===== sim/chacha20_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20 stream checker
// watches the csr, request and response channels, computes the expected
// cipher words with its own chacha20 block function and compares them in order
// ----------------------------------------------------------------------------
module chacha20_checker #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } cipher_word_type;

   logic [63:0]  key_reg [4];
   logic [63:0]  nonce_lo_reg;
   logic [31:0]  nonce_hi_reg;
   logic [31:0]  keystream [16];
   logic [3:0]   word_pos;
   logic [31:0]  blk_count;
   cipher_word_type expected_words [$];

   function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic mix(inout logic [31:0] x [16], input int a, input int b,
                      input int c, input int d);
      x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
      x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
      x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
      x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
   endtask

   task automatic build_keystream();
      logic [31:0] init [16];
      logic [31:0] work [16];
      init[0] = chacha_pkg::SIGMA0;
      init[1] = chacha_pkg::SIGMA1;
      init[2] = chacha_pkg::SIGMA2;
      init[3] = chacha_pkg::SIGMA3;
      for (int i = 0; i < 4; i++) begin
         init[4 + 2 * i] = key_reg[i][31:0];
         init[5 + 2 * i] = key_reg[i][63:32];
      end
      init[12] = blk_count;
      init[13] = nonce_lo_reg[31:0];
      init[14] = nonce_lo_reg[63:32];
      init[15] = nonce_hi_reg;
      work = init;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         mix(work, 0, 4, 8, 12);
         mix(work, 1, 5, 9, 13);
         mix(work, 2, 6, 10, 14);
         mix(work, 3, 7, 11, 15);
         mix(work, 0, 5, 10, 15);
         mix(work, 1, 6, 11, 12);
         mix(work, 2, 7, 8, 13);
         mix(work, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) keystream[i] = work[i] + init[i];
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cipher_word_type e;
      logic [31:0] mask;
      if (reset) begin
         foreach (key_reg[i]) key_reg[i] = '0;
         nonce_lo_reg = '0;
         nonce_hi_reg = '0;
         word_pos = '0;
         blk_count = 32'd1;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               chacha_pkg::REG_KEY01:    key_reg[0] = csr_data;
               chacha_pkg::REG_KEY23:    key_reg[1] = csr_data;
               chacha_pkg::REG_KEY45:    key_reg[2] = csr_data;
               chacha_pkg::REG_KEY67:    key_reg[3] = csr_data;
               chacha_pkg::REG_NONCE_LO: nonce_lo_reg = csr_data;
               chacha_pkg::REG_NONCE_HI: nonce_hi_reg = csr_data[31:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (word_pos == 4'd0) begin
               build_keystream();
               blk_count = blk_count + 32'd1;
            end
            case (req_tdata[34:32])
               3'd0:    mask = 32'h0;
               3'd1:    mask = 32'h0000_00ff;
               3'd2:    mask = 32'h0000_ffff;
               3'd3:    mask = 32'h00ff_ffff;
               default: mask = 32'hffff_ffff;
            endcase
            e.word = (req_tdata[31:0] ^ keystream[word_pos]) & mask;
            e.count = req_tdata[34:32];
            e.last = req_tlast;
            expected_words.push_back(e);
            word_pos = word_pos + 4'd1;
            if (req_tlast) begin
               word_pos = '0;
               blk_count = 32'd1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_tdata), 64'd0);
            end else begin
               e = expected_words.pop_front();
               if (rsp_tdata[31:0] !== e.word)
                  report_mismatch("out_word", 64'(rsp_tdata[31:0]), 64'(e.word));
               if (rsp_tdata[34:32] !== e.count)
                  report_mismatch("out_byte_count", 64'(rsp_tdata[34:32]), 64'(e.count));
               if (rsp_tlast !== e.last)
                  report_mismatch("out_last", 64'(rsp_tlast), 64'(e.last));
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20 stream cipher testbench
// drives packets of words under several key and nonce settings with random
// idling on both channels; the checker predicts and compares every response
// ----------------------------------------------------------------------------
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   chacha20_stream_cipher_top dut (.*);
   chacha20_checker checker_inst (.*);

   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic setup_keys(input int mode);
      logic [63:0] v;
      for (int i = 0; i <= 6; i++) begin
         case (mode)
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
         endcase
         write_reg(i[2:0], v);
      end
      write_reg(3'd7, {$urandom, $urandom});
   endtask

   task automatic send_word(input logic [31:0] w, input logic [2:0] cnt,
                            input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, cnt, w};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic send_packet(input int len);
      logic [2:0] cnt;
      for (int i = 0; i < len; i++) begin
         cnt = 3'd4;
         if ($urandom_range(19) == 0) cnt = 3'($urandom_range(7));
         else if (i == len - 1) cnt = 3'($urandom_range(1, 4));
         send_word($urandom, cnt, i == len - 1);
      end
   endtask

   initial begin
      #20ms;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int sent;
      int len;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: defaults, all-ones keys, byte counts, zero and max data
      send_word(32'h0, 3'd4, 1'b0);
      send_word(32'hffff_ffff, 3'd0, 1'b0);
      send_word(32'hffff_ffff, 3'd1, 1'b0);
      send_word(32'hffff_ffff, 3'd2, 1'b0);
      send_word(32'hffff_ffff, 3'd7, 1'b0);
      send_word(32'ha5a5_5a5a, 3'd3, 1'b1);
      wait_drained();
      setup_keys(1);
      for (int i = 0; i < 17; i++) send_word($urandom, 3'd4, i == 16);
      wait_drained();
      setup_keys(2);
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 16 : 0;
         while (sent < 650 * (phase + 1)) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
            send_packet(len);
            sent += len;
            if ($urandom_range(15) == 0) wait_drained();
         end
         wait_drained();
         setup_keys(phase == 2 ? 0 : 2);
      end
      send_packet(33);
      wait_drained();
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
